[hdl/sha1_stream_hasher_unit_macros.svh]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Concurrent check macros shared by the hasher RTL. Defining ASSERT_OFF
// removes every check.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA1_STREAM_HASHER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SHA1SH_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("SHA-1 hasher check failed");
`define SHA1SH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("SHA-1 hasher check failed");
`else
`define SHA1SH_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SHA1SH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/sha1sh_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Payload types, control types and the fixed constants of SHA-1.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned BLOCK_BITS = 512;
   localparam int unsigned ROUNDS     = 80;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       msg_end;
   } sha1sh_req_type;

   typedef struct packed {
      logic [31:0] digest_word0;
      logic [31:0] digest_word1;
      logic [31:0] digest_word2;
      logic [31:0] digest_word3;
      logic [31:0] digest_word4;
   } sha1sh_rsp_type;

   typedef struct packed {
      logic start;
      logic init;
   } sha1sh_core_cmd_type;

   typedef enum logic [2:0] {
      CORE_IDLE = 3'b001,
      CORE_RUN  = 3'b010,
      CORE_ADD  = 3'b100
   } sha1sh_core_state_type;

   typedef enum logic [3:0] {
      TOP_IDLE = 4'b0001,
      TOP_PAD  = 4'b0010,
      TOP_COMP = 4'b0100,
      TOP_DONE = 4'b1000
   } sha1sh_top_state_type;

endpackage

`default_nettype wire

[hdl/sha1sh_core.sv]
// ----------------------------------------------------------------------------
// SHA-1 compression core
// One shared round unit runs the 80 rounds over a 16-word schedule shift
// register, then folds the working words into the chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_core (
   input  logic                             clock,
   input  logic                             reset,
   input  sha1sh_pkg::sha1sh_core_cmd_type  cmd,
   input  logic [sha1sh_pkg::BLOCK_BITS-1:0] block,
   output logic                             done,
   output logic [4:0][31:0]                 chain_words
);
   import sha1sh_pkg::*;

   sha1sh_core_state_type state_ff, state_in;
   logic [6:0]            rnd_ff, rnd_in;
   logic [15:0][31:0]     w_ff, w_in;
   logic [31:0]           a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]           a_in, b_in, c_in, d_in, e_in;
   logic [4:0][31:0]      chain_ff, chain_in;
   logic [31:0]           mix, wt, f, k, tmp;

   always_comb begin
      mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      wt  = (rnd_ff < 7'd16) ? w_ff[0] : {mix[30:0], mix[31]};
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
      tmp = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wt;
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      w_in     = w_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      chain_in = chain_ff;
      unique case (state_ff)
         CORE_IDLE: begin
            if (cmd.init) begin
               chain_in = {IV4, IV3, IV2, IV1, IV0};
            end
            if (cmd.start) begin
               for (int j = 0; j < 16; j++) begin
                  w_in[j] = block[WORD_BITS*(15-j) +: WORD_BITS];
               end
               a_in     = chain_ff[0];
               b_in     = chain_ff[1];
               c_in     = chain_ff[2];
               d_in     = chain_ff[3];
               e_in     = chain_ff[4];
               rnd_in   = '0;
               state_in = CORE_RUN;
            end
         end
         CORE_RUN: begin
            w_in  = {wt, w_ff[15:1]};
            a_in  = tmp;
            b_in  = a_ff;
            c_in  = {b_ff[1:0], b_ff[31:2]};
            d_in  = c_ff;
            e_in  = d_ff;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(ROUNDS - 1)) begin
               state_in = CORE_ADD;
            end
         end
         CORE_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            state_in    = CORE_IDLE;
         end
         default: state_in = CORE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         rnd_ff   <= '0;
         chain_ff <= {IV4, IV3, IV2, IV1, IV0};
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign done        = (state_ff == CORE_ADD);
   assign chain_words = chain_ff;

endmodule

`default_nettype wire

[hdl/sha1_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Packs message bytes into 512-bit blocks, pads the message at its end and
// returns the SHA-1 digest through an output register.
//
// Usage: each transfer on the req_ channel carries at most one message byte
// (byte_valid) and may close the message (msg_end). A transfer that closes
// the message yields exactly one digest transfer on the rsp_ channel; all
// other transfers yield nothing.
// Timing: a byte that does not complete a block is taken without a stall. A
// byte that completes a block holds req_ready low while the compression core
// runs 80 rounds, one per cycle, and then folds the result into the chaining
// words. At message end the padding bytes enter one per cycle (9 to 72
// bytes), one or two compressions follow, and the digest is registered in
// TOP_DONE once the output register is free. No byte is taken while a block
// is compressed by the single round unit.
// Reset returns the chaining words to the initial values and clears the
// length count and byte position. A stalled receiver keeps the digest in
// the output register; new bytes are still taken, and only the next digest
// waits until the previous one has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_stream_hasher_unit_macros.svh"

module sha1_stream_hasher_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sha1sh_pkg::sha1sh_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sha1sh_pkg::sha1sh_rsp_type rsp_data
);
   import sha1sh_pkg::*;

   sha1sh_top_state_type     state_ff, state_in;
   logic [BLOCK_BITS-1:0]    blk_ff, blk_in;
   logic [5:0]               pos_ff, pos_in;
   logic [63:0]              bitlen_ff, bitlen_in;
   logic                     final_ff, final_in;
   logic                     marker_ff, marker_in;
   logic                     lenph_ff, lenph_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sha1sh_rsp_type           rsp_data_ff, rsp_data_in;
   logic                     feed;
   logic [7:0]               feed_byte;
   sha1sh_core_cmd_type      cmd;
   logic                     core_done;
   logic [4:0][31:0]         chain_words;

   assign req_ready = (state_ff == TOP_IDLE);

   always_comb begin
      state_in     = state_ff;
      bitlen_in    = bitlen_ff;
      final_in     = final_ff;
      marker_in    = marker_ff;
      lenph_in     = lenph_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      feed         = 1'b0;
      feed_byte    = '0;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         TOP_IDLE: begin
            if (req_valid) begin
               final_in = req_data.msg_end;
               if (req_data.byte_valid) begin
                  feed      = 1'b1;
                  feed_byte = req_data.data_byte;
                  bitlen_in = bitlen_ff + 64'd8;
               end
               if (req_data.byte_valid && pos_ff == LAST_POS) begin
                  cmd.start = 1'b1;
                  state_in  = TOP_COMP;
               end else if (req_data.msg_end) begin
                  state_in = TOP_PAD;
               end
            end
         end
         TOP_PAD: begin
            feed = 1'b1;
            if (!marker_ff) begin
               feed_byte = PAD_MARKER;
               marker_in = 1'b1;
            end else if (lenph_ff || pos_ff == LEN_POS) begin
               feed_byte = 8'(bitlen_ff >> {~pos_ff[2:0], 3'b000});
               lenph_in  = 1'b1;
            end
            if (pos_ff == LAST_POS) begin
               cmd.start = 1'b1;
               state_in  = TOP_COMP;
            end
         end
         TOP_COMP: begin
            if (core_done) begin
               if (!final_ff) begin
                  state_in = TOP_IDLE;
               end else if (lenph_ff) begin
                  state_in = TOP_DONE;
               end else begin
                  state_in = TOP_PAD;
               end
            end
         end
         TOP_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.digest_word0 = chain_words[0];
               rsp_data_in.digest_word1 = chain_words[1];
               rsp_data_in.digest_word2 = chain_words[2];
               rsp_data_in.digest_word3 = chain_words[3];
               rsp_data_in.digest_word4 = chain_words[4];
               cmd.init                 = 1'b1;
               bitlen_in                = '0;
               final_in                 = 1'b0;
               marker_in                = 1'b0;
               lenph_in                 = 1'b0;
               state_in                 = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
      blk_in = feed ? {blk_ff[BLOCK_BITS-9:0], feed_byte} : blk_ff;
      pos_in = feed ? pos_ff + 6'd1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         pos_ff       <= '0;
         bitlen_ff    <= '0;
         final_ff     <= 1'b0;
         marker_ff    <= 1'b0;
         lenph_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bitlen_ff    <= bitlen_in;
         final_ff     <= final_in;
         marker_ff    <= marker_in;
         lenph_ff     <= lenph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

   sha1sh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .block       (blk_in),
      .done        (core_done),
      .chain_words (chain_words)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SHA1SH_ASSERT_NEXT(a_end_holds_off, clock, reset, req_valid && req_ready && req_data.msg_end, !req_ready)
   `SHA1SH_ASSERT_IMPLIES(a_done_aligned, clock, reset, state_ff == TOP_DONE, pos_ff == 6'd0 && lenph_ff && marker_ff)
   `SHA1SH_ASSERT_IMPLIES(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == TOP_DONE)

endmodule

`default_nettype wire

[dv/sha1_stream_hasher_unit_tb.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Sends byte messages through the request channel and checks every digest
// transfer against a behavioral SHA-1 model kept inside the testbench. A short
// table of directed items comes first, with the well-known digests of the
// empty message and of "abc" typed in. Random messages follow, with sizes
// around the one- and two-block padding boundaries, under several patterns
// of sender gaps and receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sha1sh_pkg::*;

   typedef struct packed {
      sha1sh_req_type item;
      logic           known;
      sha1sh_rsp_type digest;
   } hash_item_type;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned HOLD_OFF_CYCLES = 1500;
   localparam int unsigned TAIL_CYCLES     = 300;
   localparam int unsigned N_DIRECTED      = 16;

   localparam sha1sh_rsp_type NO_DIGEST    = '0;
   localparam sha1sh_rsp_type EMPTY_DIGEST = '{32'hda39a3ee, 32'h5e6b4b0d,
                                               32'h3255bfef, 32'h95601890,
                                               32'hafd80709};
   localparam sha1sh_rsp_type ABC_DIGEST   = '{32'ha9993e36, 32'h4706816a,
                                               32'hba3e2571, 32'h7850c26c,
                                               32'h9cd0d89d};

   localparam hash_item_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'h5A, 1'b0, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
      '{'{8'hA5, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
      '{'{8'h00, 1'b1, 1'b1}, 1'b0, NO_DIGEST},
      '{'{8'hFF, 1'b1, 1'b1}, 1'b0, NO_DIGEST},
      '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'h00, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'hFF, 1'b0, 1'b1}, 1'b0, NO_DIGEST},
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
      '{'{8'h63, 1'b1, 1'b0}, 1'b0, NO_DIGEST}
   };

   localparam int unsigned BOUNDARY_LENS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   sha1sh_req_type req_data  = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   sha1sh_rsp_type rsp_data;

   hash_item_type  req_items[$];
   sha1sh_rsp_type pending_digests[$];

   int unsigned send_idle_pct     = 0;
   int unsigned recv_stall_pct    = 0;
   int unsigned hold_off_requests = 0;
   int unsigned hold_off_served   = 0;
   int unsigned hold_left         = 0;
   int unsigned fail_count        = 0;
   int unsigned cycle_count       = 0;

   logic [31:0] chain_h [5];
   logic [31:0] msg_block [16];
   logic [63:0] msg_bits;
   logic [5:0]  fill_pos;

   sha1_stream_hasher_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void reset_hash_state();
      chain_h  = '{IV0, IV1, IV2, IV3, IV4};
      msg_bits = '0;
      fill_pos = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, wt, tmp;
      w = msg_block;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            wt = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
            w[t % 16] = wt;
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         tmp = rotl(a, 5) + f + e + k + wt;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = tmp;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] value);
      msg_block[fill_pos[5:2]][8 * (3 - fill_pos[1:0]) +: 8] = value;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) compress_block();
   endfunction

   function automatic bit predict_digest(input sha1sh_req_type it,
                                         output sha1sh_rsp_type digest);
      logic [63:0] len;
      digest = '0;
      if (it.byte_valid) begin
         absorb_byte(it.data_byte);
         msg_bits += 64'd8;
      end
      if (!it.msg_end) return 1'b0;
      len = msg_bits;
      absorb_byte(PAD_MARKER);
      while (fill_pos != LEN_POS) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(len[8 * i +: 8]);
      digest = '{chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
      reset_hash_state();
      return 1'b1;
   endfunction

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic check_word(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want)
         log_failure($sformatf("%s expected %08h, got %08h", field, want, got));
   endtask

   task automatic check_digest(input sha1sh_rsp_type got);
      sha1sh_rsp_type want;
      if (pending_digests.size() == 0) begin
         log_failure($sformatf("digest %h with no message closed", got));
         return;
      end
      want = pending_digests.pop_front();
      check_word("digest_word0", want.digest_word0, got.digest_word0);
      check_word("digest_word1", want.digest_word1, got.digest_word1);
      check_word("digest_word2", want.digest_word2, got.digest_word2);
      check_word("digest_word3", want.digest_word3, got.digest_word3);
      check_word("digest_word4", want.digest_word4, got.digest_word4);
   endtask

   task automatic queue_messages(input int unsigned items_wanted,
                                 input int unsigned max_len,
                                 input bit with_boundaries);
      int unsigned   added;
      int unsigned   len;
      bit            end_on_byte;
      hash_item_type row;
      added = 0;
      while (added < items_wanted) begin
         len = $urandom_range(max_len, 0);
         if (with_boundaries && $urandom_range(7) == 0)
            len = BOUNDARY_LENS[$urandom_range(8)];
         end_on_byte = (len != 0) && ($urandom_range(1) == 1);
         for (int n = 0; n < len; n++) begin
            if ($urandom_range(5) == 0) begin
               row = '0;
               row.item.data_byte = 8'($urandom_range(255));
               req_items = {req_items, row};
               added++;
            end
            row = '0;
            row.item.data_byte  = 8'($urandom_range(255));
            row.item.byte_valid = 1'b1;
            row.item.msg_end    = end_on_byte && (n == len - 1);
            req_items = {req_items, row};
         end
         if (!end_on_byte) begin
            row = '0;
            row.item.data_byte = 8'($urandom_range(255));
            row.item.msg_end   = 1'b1;
            req_items = {req_items, row};
            added++;
         end
         added += len;
      end
   endtask

   task automatic wait_idle();
      while (req_items.size() != 0 || pending_digests.size() != 0) @(negedge clock);
   endtask

   // The digest for a closing transfer is predicted at the edge that accepts it.
   always @(posedge clock) begin
      sha1sh_rsp_type digest;
      bit             accepted;
      if (reset) begin
         req_valid <= 1'b0;
         reset_hash_state();
      end else begin
         accepted = req_valid && req_ready;
         if (accepted) begin
            if (predict_digest(req_items[0].item, digest)) begin
               if (req_items[0].known) digest = req_items[0].digest;
               pending_digests = {pending_digests, digest};
            end
            void'(req_items.pop_front());
         end
         if (!req_valid || accepted) begin
            if (req_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= req_items[0].item;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_digest(rsp_data);
         if (hold_off_served != hold_off_requests) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < N_DIRECTED; r++) req_items = {req_items, DIRECTED_ROWS[r]};
      queue_messages(85, 12, 1'b1);
      wait_idle();

      send_idle_pct = 67;
      queue_messages(85, 12, 1'b1);
      wait_idle();

      send_idle_pct  = 0;
      recv_stall_pct = 67;
      queue_messages(85, 12, 1'b1);
      wait_idle();

      // Short messages pile up behind a receiver that holds off for a long time.
      recv_stall_pct = 0;
      hold_off_requests++;
      queue_messages(50, 3, 1'b0);
      wait_idle();

      send_idle_pct  = 9;
      recv_stall_pct = 9;
      queue_messages(90, 12, 1'b1);
      wait_idle();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_digests.size() != 0)
         log_failure($sformatf("%0d digests never arrived", pending_digests.size()));
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
